### rtl/tcce_pkg.sv
// Shared constants, codes and types of the text console character engine.
package tcce_pkg;

   // Default screen geometry.
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Fixed field widths of the request and response channels.
   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int OFFSET_W = 11;
   localparam int ATTR_W   = 8;
   localparam int CELL_DW  = CHAR_W + ATTR_W;

   // Attribute register value after reset.
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Control characters handled by put-character.
   localparam logic [CHAR_W-1:0] CHAR_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_BKSP,
      ST_SCROLL,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Commands to the address sweep counter.
   typedef struct packed {
      logic clear;
      logic step;
   } sweep_ctrl_type;

   // Status from the address sweep counter.
   typedef struct packed {
      logic last;
      logic copy;
   } sweep_status_type;

endpackage

### rtl/tcce_req_if.sv
// Request channel of the text console character engine.
interface tcce_req_if;
   import tcce_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [CHAR_W-1:0]  char_code;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, output cmd, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input cmd, input char_code, input cell_index,
                   output ready);
endinterface

### rtl/tcce_rsp_if.sv
// Response channel of the text console character engine.
interface tcce_rsp_if;
   import tcce_pkg::*;

   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] cursor_offset;
   logic [CHAR_W-1:0]   read_char;
   logic [ATTR_W-1:0]   read_attr;

   modport source (output valid, output cursor_offset, output read_char,
                   output read_attr, input ready);
   modport sink   (input valid, input cursor_offset, input read_char,
                   input read_attr, output ready);
endinterface

### rtl/tcce_ram.sv
// Screen store: one write port and one registered read port.
module tcce_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                         clock,
   input  logic                         write_enable,
   input  logic [ADDR_W-1:0]            write_addr,
   input  logic [tcce_pkg::CELL_DW-1:0] write_data,
   input  logic                         read_enable,
   input  logic [ADDR_W-1:0]            read_addr,
   output logic [tcce_pkg::CELL_DW-1:0] read_data
);
   import tcce_pkg::*;

   logic [CELL_DW-1:0] mem_ff [DEPTH];
   logic [CELL_DW-1:0] read_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   // Read port; a read at a written address returns the old word.
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

### rtl/tcce_sweep.sv
// Address sweep counter shared by the reset clear, screen clear and scroll passes.
module tcce_sweep #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int CELL_W  = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tcce_pkg::sweep_ctrl_type   ctrl,
   input  logic [CELL_W-1:0]          limit,
   output logic [CELL_W-1:0]          count,
   output logic [CELL_W-1:0]          ahead,
   output tcce_pkg::sweep_status_type status
);
   import tcce_pkg::*;

   // Cells that a scroll copies from the row below; the rest of the pass blanks.
   localparam int COPY_CELLS = (ROWS - 2) * COLUMNS;

   logic [CELL_W-1:0] count_ff;
   logic [CELL_W-1:0] count_in;

   // Counter update.
   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.step) begin
         count_in = count_ff + CELL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Source address one row ahead, end compare and copy phase.
   assign count       = count_ff;
   assign ahead       = count_ff + CELL_W'(COLUMNS);
   assign status.last = (count_ff == limit);
   assign status.copy = ({1'b0, count_ff} < (CELL_W+1)'(COPY_CELLS));

endmodule

### rtl/text_console_character_engine_top.sv
// Top level of the text console character engine: sequencer, cursor and response register.
// Each request is taken when the engine is idle and its response is held in an output
// register, so a new request can be taken while an earlier response waits. A read inside
// the screen or a backspace that moves the cursor passes through an extra state (ST_READ or
// ST_BKSP) before its response, because the screen store has one write port and one
// registered read port. A line feed or wrap on the last text row scrolls the screen, and
// a clear-screen request blanks the text rows; both walk the store one cell per cycle with
// the shared sweep counter. After reset the store is zeroed by a sweep pass, during which
// no request is taken; attribute writes are taken at any time. The bottom row of the
// screen is never written by text output.
module text_console_character_engine_top #(
   parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   tcce_req_if.sink                    req_chan,
   tcce_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_enable,
   input  logic [tcce_pkg::ATTR_W-1:0] csr_write_data
);
   import tcce_pkg::*;

   localparam int CELLS      = ROWS * COLUMNS;
   localparam int TEXT_CELLS = (ROWS - 1) * COLUMNS;
   localparam int CELL_W     = $clog2(CELLS);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int CMP_W      = ((CELL_W > INDEX_W) ? CELL_W : INDEX_W) + 1;

   // Sequencer and cursor.
   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ATTR_W-1:0] attr_ff;

   // Pending write into the screen store.
   logic               pend_valid_ff, pend_valid_in;
   logic               pend_copy_ff, pend_copy_in;
   logic [CELL_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [CELL_DW-1:0] pend_data_ff, pend_data_in;

   // Read result and response register.
   logic [CHAR_W-1:0]   rd_char_ff, rd_char_in;
   logic [ATTR_W-1:0]   rd_attr_ff, rd_attr_in;
   logic                rsp_valid_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [ATTR_W-1:0]   rsp_attr_ff;
   logic                rsp_load;

   // Store ports and sweep counter.
   logic               ram_re;
   logic [CELL_W-1:0]  ram_raddr;
   logic [CELL_DW-1:0] ram_rdata;
   logic [CELL_DW-1:0] ram_wdata;
   sweep_ctrl_type     sweep_ctrl;
   sweep_status_type   sweep_status;
   logic [CELL_W-1:0]  sweep_limit;
   logic [CELL_W-1:0]  sweep_count;
   logic [CELL_W-1:0]  sweep_ahead;

   // Put-character decode.
   logic [COL_W:0]     col_next;
   logic [COL_W-1:0]   put_col;
   logic               put_row_inc;
   logic               put_write;
   logic               put_bksp;
   logic               put_scroll;

   logic               accept;
   logic               out_free;
   logic               read_in_range;
   logic [CELL_W-1:0]  cur_lin;
   logic [CELL_DW-1:0] blank_word;

   assign accept        = req_chan.valid && req_chan.ready;
   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign read_in_range = (CMP_W'(req_chan.cell_index) < CMP_W'(CELLS));
   assign cur_lin       = CELL_W'(CELL_W'(row_ff) * CELL_W'(COLUMNS)) + CELL_W'(col_ff);
   assign blank_word    = {attr_ff, {CHAR_W{1'b0}}};

   // A request is taken once the last write of a pass has landed.
   assign req_chan.ready = (state_ff == ST_IDLE) && !pend_valid_ff;

   tcce_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (CELL_W)
   ) u_ram (
      .clock        (clock),
      .write_enable (pend_valid_ff),
      .write_addr   (pend_addr_ff),
      .write_data   (ram_wdata),
      .read_enable  (ram_re),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );

   tcce_sweep #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CELL_W  (CELL_W)
   ) u_sweep (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (sweep_ctrl),
      .limit  (sweep_limit),
      .count  (sweep_count),
      .ahead  (sweep_ahead),
      .status (sweep_status)
   );

   // A scroll copy writes the word that the previous cycle's read left in the read register.
   assign ram_wdata = pend_copy_ff ? ram_rdata : pend_data_ff;

   // Cursor movement for the character of the request.
   always_comb begin
      col_next    = {1'b0, col_ff};
      put_row_inc = 1'b0;
      put_write   = 1'b0;
      put_bksp    = 1'b0;
      case (req_chan.char_code)
         CHAR_BS: begin
            if (col_ff != '0) begin
               col_next = {1'b0, col_ff} - (COL_W+1)'(1);
               put_bksp = 1'b1;
            end
         end
         CHAR_TAB: begin
            col_next = ({1'b0, col_ff} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
         end
         CHAR_CR: begin
            col_next = '0;
         end
         CHAR_LF: begin
            col_next    = '0;
            put_row_inc = 1'b1;
         end
         default: begin
            col_next  = {1'b0, col_ff} + (COL_W+1)'(1);
            put_write = 1'b1;
         end
      endcase
      if (col_next >= (COL_W+1)'(COLUMNS)) begin
         col_next    = '0;
         put_row_inc = 1'b1;
      end
      put_col    = col_next[COL_W-1:0];
      put_scroll = put_row_inc && (row_ff == ROW_W'(ROWS - 2));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sweep_status.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.cmd)
                  CMD_PUT: begin
                     if (put_bksp) begin
                        state_in = ST_BKSP;
                     end else if (put_scroll) begin
                        state_in = ST_SCROLL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  CMD_READ:  state_in = read_in_range ? ST_READ : ST_DONE;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_BKSP: state_in = ST_DONE;
         ST_SCROLL, ST_CLEAR: begin
            if (sweep_status.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls per state.
   always_comb begin
      sweep_ctrl    = '0;
      sweep_limit   = CELL_W'(TEXT_CELLS - 1);
      ram_re        = 1'b0;
      ram_raddr     = sweep_ahead;
      pend_valid_in = 1'b0;
      pend_copy_in  = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      rd_char_in    = rd_char_ff;
      rd_attr_in    = rd_attr_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_INIT: begin
            sweep_limit     = CELL_W'(CELLS - 1);
            sweep_ctrl.step = 1'b1;
            pend_valid_in   = 1'b1;
            pend_addr_in    = sweep_count;
            pend_data_in    = '0;
         end
         ST_IDLE: begin
            sweep_ctrl.clear = 1'b1;
            if (accept) begin
               rd_char_in = '0;
               rd_attr_in = '0;
               case (req_chan.cmd)
                  CMD_PUT: begin
                     col_in = put_col;
                     if (put_row_inc && !put_scroll) begin
                        row_in = row_ff + ROW_W'(1);
                     end
                     if (put_write) begin
                        pend_valid_in = 1'b1;
                        pend_addr_in  = cur_lin;
                        pend_data_in  = {attr_ff, req_chan.char_code};
                     end
                     if (put_bksp) begin
                        ram_re    = 1'b1;
                        ram_raddr = cur_lin - CELL_W'(1);
                     end
                  end
                  CMD_READ: begin
                     if (read_in_range) begin
                        ram_re    = 1'b1;
                        ram_raddr = CELL_W'(req_chan.cell_index);
                     end
                  end
                  CMD_CLEAR: begin
                     col_in = '0;
                     row_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_char_in = ram_rdata[CHAR_W-1:0];
            rd_attr_in = ram_rdata[CELL_DW-1:CHAR_W];
         end
         ST_BKSP: begin
            // The cursor already stands on the erased cell.
            pend_valid_in = 1'b1;
            pend_addr_in  = cur_lin;
            pend_data_in  = {ram_rdata[CELL_DW-1:CHAR_W], {CHAR_W{1'b0}}};
         end
         ST_SCROLL: begin
            sweep_ctrl.step = 1'b1;
            pend_valid_in   = 1'b1;
            pend_addr_in    = sweep_count;
            if (sweep_status.copy) begin
               ram_re       = 1'b1;
               ram_raddr    = sweep_ahead;
               pend_copy_in = 1'b1;
            end else begin
               pend_data_in = blank_word;
            end
         end
         ST_CLEAR: begin
            sweep_ctrl.step = 1'b1;
            pend_valid_in   = 1'b1;
            pend_addr_in    = sweep_count;
            pend_data_in    = blank_word;
         end
         ST_DONE: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         col_ff        <= '0;
         row_ff        <= '0;
         attr_ff       <= ATTR_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_copy_ff <= pend_copy_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      rd_char_ff   <= rd_char_in;
      rd_attr_ff   <= rd_attr_in;
      if (rsp_load) begin
         rsp_offset_ff <= OFFSET_W'(cur_lin);
         rsp_char_ff   <= rd_char_ff;
         rsp_attr_ff   <= rd_attr_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cursor_offset = rsp_offset_ff;
   assign rsp_chan.read_char     = rsp_char_ff;
   assign rsp_chan.read_attr     = rsp_attr_ff;

endmodule

### tb/text_console_character_engine_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text console character engine: a screen tracker predicts every response.
module text_console_character_engine_top_tb;
   import tcce_pkg::*;

   localparam int SCREEN_COLS    = COLUMNS_DEFAULT;
   localparam int SCREEN_ROWS    = ROWS_DEFAULT;
   localparam int SCREEN_CELLS   = SCREEN_ROWS * SCREEN_COLS;
   localparam int TAB_STOP       = 8;
   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 11;
   localparam int SWEEP_CYCLES   = (SCREEN_ROWS - 1) * SCREEN_COLS + 2;
   localparam int SETTLE_CYCLES  = 4;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REQUESTS = 50;
   localparam longint TIMEOUT_CYCLES = 5_000_000;

   // Command code that the engine answers without acting on it.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // One expected response.
   typedef struct packed {
      logic [OFFSET_W-1:0] cursor_offset;
      logic [CHAR_W-1:0]   read_char;
      logic [ATTR_W-1:0]   read_attr;
   } console_reply_type;

   // Tracks the screen store and cursor, and checks responses in order.
   class console_screen_tracker;
      logic [CELL_DW-1:0] cells [SCREEN_CELLS];
      int unsigned        column;
      int unsigned        row;
      logic [ATTR_W-1:0]  attribute;
      console_reply_type  awaited[$];
      int unsigned        mismatches;

      function new();
         foreach (cells[i]) cells[i] = '0;
         column     = 0;
         row        = 0;
         attribute  = ATTR_RESET;
         mismatches = 0;
      endfunction

      // Blank rows first..last-1 with the current attribute.
      function void blank_rows(int unsigned first, int unsigned last);
         for (int unsigned i = first * SCREEN_COLS; i < last * SCREEN_COLS; i++)
            cells[i] = {attribute, {CHAR_W{1'b0}}};
      endfunction

      // Move the screen up one line, keeping the bottom row, and blank the lowest text row.
      function void scroll_up();
         for (int unsigned i = 0; i + SCREEN_COLS < SCREEN_CELLS; i++)
            cells[i] = cells[i + SCREEN_COLS];
         blank_rows(SCREEN_ROWS - 2, SCREEN_ROWS - 1);
         if (row > 0)
            row--;
         else
            column = 0;
      endfunction

      // Put-character, including the control codes, wrap and scroll.
      function void place_char(logic [CHAR_W-1:0] ch);
         int unsigned at;
         at = row * SCREEN_COLS + column;
         case (ch)
            CHAR_BS: begin
               if (column > 0) begin
                  column--;
                  cells[at - 1][CHAR_W-1:0] = '0;
               end
            end
            CHAR_TAB: column = (column / TAB_STOP + 1) * TAB_STOP;
            CHAR_CR:  column = 0;
            CHAR_LF: begin
               column = 0;
               row++;
            end
            default: begin
               cells[at] = {attribute, ch};
               column++;
            end
         endcase
         if (column >= SCREEN_COLS) begin
            column = 0;
            row++;
         end
         if (row >= SCREEN_ROWS - 1)
            scroll_up();
      endfunction

      // Apply an accepted request and queue the response it must produce.
      function void note_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                 logic [INDEX_W-1:0] index);
         console_reply_type reply;
         reply = '0;
         case (cmd)
            CMD_PUT: place_char(ch);
            CMD_READ: begin
               if (index < SCREEN_CELLS) begin
                  reply.read_char = cells[index][CHAR_W-1:0];
                  reply.read_attr = cells[index][CELL_DW-1:CHAR_W];
               end
            end
            CMD_CLEAR: begin
               blank_rows(0, SCREEN_ROWS - 1);
               column = 0;
               row    = 0;
            end
            default: ;
         endcase
         reply.cursor_offset = OFFSET_W'(row * SCREEN_COLS + column);
         awaited.push_back(reply);
      endfunction

      // Compare one accepted response with the oldest expectation.
      function void check_response(logic [OFFSET_W-1:0] offset, logic [CHAR_W-1:0] rchar,
                                   logic [ATTR_W-1:0] rattr);
         console_reply_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response: offset %0d char %h attr %h",
                     $time, offset, rchar, rattr);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (offset !== want.cursor_offset) begin
            $display("%0t: cursor_offset expected %0d actual %0d",
                     $time, want.cursor_offset, offset);
            mismatches++;
         end
         if (rchar !== want.read_char) begin
            $display("%0t: read_char expected %h actual %h", $time, want.read_char, rchar);
            mismatches++;
         end
         if (rattr !== want.read_attr) begin
            $display("%0t: read_attr expected %h actual %h", $time, want.read_attr, rattr);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [ATTR_W-1:0]   csr_write_data;
   bit                  quiet_tail;
   bit                  long_hold_request;
   console_screen_tracker screen_tracker;

   tcce_req_if req_chan ();
   tcce_rsp_if rsp_chan ();

   text_console_character_engine_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("[text_console_character_engine_top] ERROR");
      $finish;
   end

   // Offer one request, with an occasional gap before it, and wait for acceptance.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                               input logic [INDEX_W-1:0] index);
      int unsigned gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= cmd;
      req_chan.char_code  <= ch;
      req_chan.cell_index <= index;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      screen_tracker.note_request(cmd, ch, index);
   endtask

   // Change the text attribute once every outstanding response is back.
   task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (screen_tracker.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      screen_tracker.attribute = value;
   endtask

   // Response sink: random stall bursts, calm stretches and one long hold.
   initial begin : response_sink
      int unsigned hold_cycles;
      int unsigned calm_cycles;
      hold_cycles    = 0;
      calm_cycles    = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_cycles       = LONG_HOLD;
         end else if (calm_cycles > 0) begin
            calm_cycles--;
         end else if (!quiet_tail) begin
            case ($urandom_range(0, 9))
               0, 1:    hold_cycles = $urandom_range(1, 16);
               2:       calm_cycles = $urandom_range(20, 200);
               default: ;
            endcase
         end
         rsp_chan.ready <= (hold_cycles == 0);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         screen_tracker.check_response(rsp_chan.cursor_offset, rsp_chan.read_char,
                                       rsp_chan.read_attr);
   end

   // Main sequence: reset, directed requests, then random phases with new attributes.
   initial begin : stimulus
      int unsigned        phase;
      int unsigned        issued;
      int unsigned        burst_kind;
      int unsigned        burst_len;
      int unsigned        near_cell;
      int unsigned        back;
      logic [CHAR_W-1:0]  ch;
      logic [INDEX_W-1:0] read_cell;

      screen_tracker      = new();
      quiet_tail          = 1'b0;
      long_hold_request   = 1'b0;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_PUT;
      req_chan.char_code  = '0;
      req_chan.cell_index = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset attribute.
      send_request(CMD_READ, 8'h00, 11'd0);
      send_request(CMD_PUT, 8'h41, 11'd0);
      send_request(CMD_PUT, 8'h00, 11'h7FF);
      send_request(CMD_PUT, 8'hFF, 11'd0);
      send_request(CMD_READ, 8'hFF, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd2);
      send_request(CMD_PUT, CHAR_BS, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd2);
      send_request(CMD_PUT, CHAR_TAB, 11'd0);
      send_request(CMD_PUT, CHAR_TAB, 11'd0);
      send_request(CMD_PUT, CHAR_CR, 11'd0);
      // Backspace at the left edge leaves everything as it is.
      send_request(CMD_PUT, CHAR_BS, 11'd0);
      send_request(CMD_PUT, CHAR_LF, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd1999);
      send_request(CMD_READ, 8'h00, 11'd2000);
      send_request(CMD_READ, 8'h00, 11'h7FF);
      send_request(CMD_UNUSED, 8'hFF, 11'h7FF);
      send_request(CMD_CLEAR, 8'h00, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd1919);

      // Random part: bursts of text lines, line feeds, reads and clears.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            write_text_attribute(8'h00);
         else if (phase == 1)
            write_text_attribute(8'hFF);
         else
            write_text_attribute(ATTR_W'($urandom_range(0, 255)));
         if (phase == 2)
            long_hold_request = 1'b1;
         if (phase == RANDOM_PHASES - 1)
            quiet_tail = 1'b1;
         issued = 0;
         while (issued < PHASE_REQUESTS) begin
            burst_kind = $urandom_range(0, 99);
            if (burst_kind < 40) begin
               // A line of text with a sprinkle of control codes; long lines wrap.
               burst_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100)
                                                       : $urandom_range(1, 30);
               repeat (burst_len) begin
                  case ($urandom_range(0, 19))
                     0:       ch = CHAR_BS;
                     1:       ch = CHAR_TAB;
                     2:       ch = CHAR_CR;
                     default: ch = CHAR_W'($urandom_range(0, 255));
                  endcase
                  send_request(CMD_PUT, ch, INDEX_W'($urandom));
               end
               issued += burst_len;
               if ($urandom_range(0, 1) == 1) begin
                  send_request(CMD_PUT, CHAR_LF, INDEX_W'($urandom));
                  issued++;
               end
            end else if (burst_kind < 52) begin
               // A run of line feeds pushes the cursor to the bottom and scrolls.
               burst_len = $urandom_range(1, 30);
               repeat (burst_len)
                  send_request(CMD_PUT, CHAR_LF, INDEX_W'($urandom));
               issued += burst_len;
            end else if (burst_kind < 80) begin
               // Reads, mostly just behind the cursor where text was written.
               burst_len = $urandom_range(1, 6);
               repeat (burst_len) begin
                  if ($urandom_range(0, 2) == 0) begin
                     read_cell = INDEX_W'($urandom);
                  end else begin
                     near_cell = screen_tracker.row * SCREEN_COLS + screen_tracker.column;
                     back      = $urandom_range(0, 100);
                     read_cell = INDEX_W'((near_cell > back) ? near_cell - back : 0);
                  end
                  send_request(CMD_READ, CHAR_W'($urandom), read_cell);
               end
               issued += burst_len;
            end else if (burst_kind < 83) begin
               send_request(CMD_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
               issued++;
            end else if (burst_kind < 88) begin
               // Unused command code, answered without effect; not counted.
               send_request(CMD_UNUSED, CHAR_W'($urandom), INDEX_W'($urandom));
            end else begin
               send_request(CMD_PUT, CHAR_W'($urandom), INDEX_W'($urandom));
               issued++;
            end
         end
      end

      // Drain and finish.
      req_chan.valid <= 1'b0;
      while (screen_tracker.awaited.size() != 0) @(posedge clock);
      repeat (SWEEP_CYCLES) @(posedge clock);
      if (screen_tracker.mismatches == 0)
         $display("[text_console_character_engine_top] OK");
      else
         $display("[text_console_character_engine_top] ERROR");
      $finish;
   end

endmodule
